### rtl/kmc_pkg.sv
// Shared constants for the k-mer set match counter.
// Used by kmc_table_ram and kmer_set_match_counter; no dependencies.
package kmc_pkg;

  localparam int KEY_W   = 64;
  localparam int COUNT_W = 16;
  localparam int KLEN_W  = 6;
  localparam int RUN_W   = 6;

  // op field codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_BASE   = 1'b1;

  // kind field codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [7:0] ASCII_A = 8'h41;
  localparam logic [7:0] ASCII_C = 8'h43;
  localparam logic [7:0] ASCII_G = 8'h47;
  localparam logic [7:0] ASCII_T = 8'h54;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_dec_t;

  function automatic base_dec_t decode_base(input logic [7:0] c);
    base_dec_t d;
    d.ok   = 1'b1;
    d.code = 2'd0;
    case (c)
      ASCII_A: d.code = 2'd0;
      ASCII_C: d.code = 2'd1;
      ASCII_G: d.code = 2'd2;
      ASCII_T: d.code = 2'd3;
      default: d.ok   = 1'b0;
    endcase
    return d;
  endfunction

endpackage

### rtl/kmer_set_match_counter.sv
// Flow: a last base without a lookup goes from idle to the emit state and then into the
// output register; otherwise every table probe (per key for an insert) passes the issue and
// check states, and the emit state then loads the output register. One item at a time: input
// is stalled until the item is done; a full table costs an issue and a check per slot probed.
// Reset: synchronous; afterwards a clearing pass over every table slot marks it empty
// while input is stalled. klen resets to 31.
module kmer_set_match_counter #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_KMER    = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // item input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [kmc_pkg::KEY_W-1:0]     kmer_value,
  input  logic [7:0]                    base,
  input  logic                          last,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [kmc_pkg::COUNT_W-1:0]   match_count,
  output logic                          table_full,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kmc_pkg::KLEN_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int KW    = kmc_pkg::KEY_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  logic [2:0]                      state;
  logic [IDX_W-1:0]                idx;
  logic [IDX_W-1:0]                probe_cnt;
  logic [KW-1:0]                   key;
  logic [KW-1:0]                   key2;
  logic                            need_second;
  logic                            on_second;
  logic                            full_flag;
  logic                            is_read;
  logic                            last_flag;
  logic [KW-1:0]                   window_bits;
  logic [kmc_pkg::RUN_W-1:0]       clean_run;
  logic [kmc_pkg::COUNT_W-1:0]     read_count;
  logic [kmc_pkg::KLEN_W-1:0]      klen;

  // hash: fold the key into the index width, then bring it below the depth
  function automatic logic [IDX_W-1:0] hash_idx(input logic [KW-1:0] v);
    logic [IDX_W-1:0] h;
    logic [IDX_W:0]   hx;
    h = '0;
    for (int i = 0; i < KW; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ v[i];
    end
    hx = {1'b0, h};
    if (hx >= (IDX_W+1)'(TABLE_DEPTH)) begin
      hx = hx - (IDX_W+1)'(TABLE_DEPTH);
    end
    return hx[IDX_W-1:0];
  endfunction

  // effective k
  logic [kmc_pkg::KLEN_W-1:0] k_eff;
  always_comb begin
    if (klen == '0) begin
      k_eff = kmc_pkg::KLEN_W'(1);
    end else if (klen > kmc_pkg::KLEN_W'(MAX_KMER)) begin
      k_eff = kmc_pkg::KLEN_W'(MAX_KMER);
    end else begin
      k_eff = klen;
    end
  end

  logic [KW-1:0] kmask;
  assign kmask = ~({KW{1'b1}} << {k_eff, 1'b0});

  // forward key and reverse complement
  logic [KW-1:0] fwd;
  logic [KW-1:0] rev_all;
  logic [KW-1:0] rc;
  logic [6:0]    rc_shift;
  assign fwd = kmer_value & kmask;
  always_comb begin
    for (int j = 0; j < KW/2; j++) begin
      rev_all[2*(KW/2-1-j) +: 2] = ~fwd[2*j +: 2];
    end
  end
  assign rc_shift = 7'(KW) - {k_eff, 1'b0};
  assign rc       = rev_all >> rc_shift;

  // base decode and next window
  kmc_pkg::base_dec_t          dec;
  logic [KW-1:0]               window_new;
  logic [kmc_pkg::RUN_W-1:0]   run_new;
  logic [KW-1:0]               window_key;
  assign dec        = kmc_pkg::decode_base(base);
  assign window_new = {window_bits[KW-3:0], dec.code};
  assign run_new    = (clean_run == kmc_pkg::RUN_MAX) ? clean_run : clean_run + 1'b1;
  assign window_key = window_new & kmask;

  // table memory
  logic              ram_wr_en;
  logic [KW:0]       ram_wr_data;
  logic              ram_rd_en;
  logic [KW:0]       rd_word;

  logic              slot_valid;
  logic              hit;
  logic              exhausted;
  logic              resolve;

  assign slot_valid = rd_word[KW];
  assign hit        = slot_valid && (rd_word[KW-1:0] == key);
  assign exhausted  = (probe_cnt == IDX_LAST);
  assign resolve    = hit || !slot_valid || exhausted;

  assign ram_rd_en   = (state == ST_ISSUE);
  assign ram_wr_en   = (state == ST_CLEAR) ||
                       (state == ST_CHECK && !is_read && !slot_valid);
  assign ram_wr_data = (state == ST_CLEAR) ? '0 : {1'b1, key};

  kmc_table_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (idx),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx),
    .rd_data (rd_word)
  );

  logic in_xfer;
  logic out_load;
  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_load  = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      klen <= kmc_pkg::KLEN_W'(31);
    end else if (cfg_valid && cfg_ready) begin
      klen <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      idx         <= '0;
      window_bits <= '0;
      clean_run   <= '0;
      read_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          if (idx == IDX_LAST) begin
            state <= ST_IDLE;
          end
          idx <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
        end

        ST_IDLE: begin
          if (in_xfer) begin
            probe_cnt <= '0;
            last_flag <= last;
            if (op == kmc_pkg::OP_INSERT) begin
              is_read     <= 1'b0;
              key         <= fwd;
              key2        <= rc;
              need_second <= (rc != fwd);
              on_second   <= 1'b0;
              full_flag   <= 1'b0;
              idx         <= hash_idx(fwd);
              state       <= ST_ISSUE;
            end else begin
              is_read <= 1'b1;
              if (dec.ok) begin
                window_bits <= window_new;
                clean_run   <= run_new;
              end else begin
                window_bits <= window_bits << 2;
                clean_run   <= '0;
              end
              if (dec.ok && run_new >= k_eff) begin
                key   <= window_key;
                idx   <= hash_idx(window_key);
                state <= ST_ISSUE;
              end else if (last) begin
                state <= ST_EMIT;
              end
            end
          end
        end

        ST_ISSUE: begin
          state <= ST_CHECK;
        end

        ST_CHECK: begin
          if (!resolve) begin
            idx       <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
            probe_cnt <= probe_cnt + 1'b1;
            state     <= ST_ISSUE;
          end else if (is_read) begin
            if (hit && read_count != kmc_pkg::COUNT_MAX) begin
              read_count <= read_count + 1'b1;
            end
            state <= last_flag ? ST_EMIT : ST_IDLE;
          end else begin
            // absent and every slot taken
            if (slot_valid && !hit) begin
              full_flag <= 1'b1;
            end
            if (need_second && !on_second) begin
              on_second <= 1'b1;
              key       <= key2;
              idx       <= hash_idx(key2);
              probe_cnt <= '0;
              state     <= ST_ISSUE;
            end else begin
              state <= ST_EMIT;
            end
          end
        end

        ST_EMIT: begin
          if (out_load) begin
            if (is_read) begin
              window_bits <= '0;
              clean_run   <= '0;
              read_count  <= '0;
            end
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind        <= is_read ? kmc_pkg::KIND_READ : kmc_pkg::KIND_INSERT;
      match_count <= is_read ? read_count : '0;
      table_full  <= !is_read && full_flag;
    end
  end

  // a key is only ever written into an empty slot
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && ram_wr_en) |-> !slot_valid)
    else $error("table write over an occupied slot");

  // the probe never wraps past the whole table
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (probe_cnt <= IDX_LAST))
    else $error("probe count beyond table depth");

  // a read report leaves the per-read state cleared
  assert property (@(posedge clk) disable iff (rst)
    (out_load && is_read) |=> (read_count == '0 && clean_run == '0 && window_bits == '0))
    else $error("read state not cleared after report");

  // insert answers carry no count, read reports no full flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == kmc_pkg::KIND_INSERT && match_count == '0) ||
                   (kind == kmc_pkg::KIND_READ && !table_full)))
    else $error("result fields inconsistent with kind");

endmodule

### rtl/kmc_table_ram.sv
// Hash table storage: one write port, one registered read port.
// Each word is {valid, key}. Depends on kmc_pkg.
module kmc_table_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic [kmc_pkg::KEY_W:0]  wr_data,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic [kmc_pkg::KEY_W:0]  rd_data
);

  logic [kmc_pkg::KEY_W:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
